// File: sv/blbp_pkg.sv
package blbp_pkg;

  // Lattice limits
  localparam int MAX_STEPS = 1024;
  localparam int ADDR_W    = $clog2(MAX_STEPS + 1);
  localparam int STEP_W    = 11;
  localparam int FACTOR_FRAC = 30;
  localparam logic [31:0] FACTOR_ONE = 32'd1073741824;
  localparam logic [31:0] PRICE_MAX  = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [7:0] REG_UP_FACTOR   = 8'd0;
  localparam logic [7:0] REG_DOWN_FACTOR = 8'd1;
  localparam logic [7:0] REG_UP_PROB     = 8'd2;
  localparam logic [7:0] REG_DISCOUNT    = 8'd3;
  localparam logic [7:0] REG_STRIKE      = 8'd4;
  localparam logic [7:0] REG_BARRIER     = 8'd5;
  localparam logic [7:0] REG_STEP_COUNT  = 8'd6;
  localparam logic [7:0] REG_MODE        = 8'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_W,
    ST_ROW_M,
    ST_TRM_W,
    ST_TRM_U1,
    ST_TRM_U2,
    ST_LVL_RD,
    ST_LVL_LD,
    ST_ND_0,
    ST_ND_1,
    ST_ND_2,
    ST_ND_3,
    ST_ND_4,
    ST_ND_5
  } state_t;

  // Round half up a Q2.30 product back to a price, saturating
  function automatic logic [31:0] scale_round(input logic [63:0] prod);
    logic [64:0] sum;
    logic [34:0] sh;
    sum = {1'b0, prod} + 65'(1 << (FACTOR_FRAC - 1));
    sh  = sum[64:FACTOR_FRAC];
    return (|sh[34:32]) ? PRICE_MAX : sh[31:0];
  endfunction

endpackage

// File: sv/blbp_ram.sv
module blbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/binomial_lattice_bond_pricer.sv
// One word at a time: the next start is taken once busy drops.
// All products go through one shared 32x32 multiplier.
// Error words (bad steps, zero spot, probability above one) come out in the cycle after start.
// Synchronous active-high reset clears state, result word and configuration registers to their defaults;
// the datapath registers and the value and price memories are undefined until written. The receiver cannot stall.
module binomial_lattice_bond_pricer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  spot_price,
  output logic                         busy,
  output logic                         done,
  output logic [31:0]                  fair_value,
  output logic                         status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [7:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import blbp_pkg::*;

  // configuration registers
  logic [31:0] up_factor, down_factor, strike_price, barrier_price;
  logic [30:0] up_probability, step_discount;
  logic [STEP_W-1:0] step_count;
  logic [1:0] mode_bits;

  state_t state, state_next;
  logic [ADDR_W-1:0] j, i;
  logic [31:0] rs, node, v0, v1;
  logic [63:0] prod, acc;
  logic [31:0] mul_a, mul_b;
  logic [30:0] pd;

  logic              val_we, prc_we;
  logic [ADDR_W-1:0] val_waddr, val_raddr, prc_waddr, prc_raddr;
  logic [31:0]       val_wdata, val_rdata, prc_wdata, prc_rdata;

  logic        call_m, amer_m, bad_in;
  logic [31:0] sc, payoff, mix, node_v;
  logic [64:0] mix_sum;
  logic        j_eq_n, j_eq_i;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign call_m    = mode_bits[0];
  assign amer_m    = mode_bits[1];
  assign pd        = 31'(FACTOR_ONE) - up_probability;
  assign sc        = scale_round(prod);
  assign j_eq_n    = (STEP_W'(j) == step_count);
  assign j_eq_i    = (j == i);
  assign bad_in    = (step_count == '0) || (step_count > STEP_W'(MAX_STEPS))
                   || (spot_price == '0) || ({1'b0, up_probability} > FACTOR_ONE);

  // terminal payoff
  assign payoff = call_m ? ((node >= strike_price) ? node : strike_price) : '0;

  // weighted child sum back to a price
  always_comb begin
    logic [33:0] sh;
    mix_sum = {1'b0, acc} + {1'b0, prod} + 65'(1 << (FACTOR_FRAC - 1));
    sh      = mix_sum[63:FACTOR_FRAC];
    mix     = (|sh[33:32] || mix_sum[64]) ? PRICE_MAX : sh[31:0];
  end

  // barrier and early conversion tests
  always_comb begin
    node_v = sc;
    if (node >= barrier_price) begin
      node_v = node;
    end else if (amer_m && call_m && node >= strike_price && node > sc) begin
      node_v = node;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start && !bad_in) state_next = ST_ROW_W;
      ST_ROW_W:  state_next = j_eq_n ? ST_TRM_W : ST_ROW_M;
      ST_ROW_M:  state_next = ST_ROW_W;
      ST_TRM_W:  state_next = j_eq_n ? ST_LVL_RD : ST_TRM_U1;
      ST_TRM_U1: state_next = ST_TRM_U2;
      ST_TRM_U2: state_next = ST_TRM_W;
      ST_LVL_RD: state_next = ST_LVL_LD;
      ST_LVL_LD: state_next = ST_ND_0;
      ST_ND_0:   state_next = ST_ND_1;
      ST_ND_1:   state_next = ST_ND_2;
      ST_ND_2:   state_next = ST_ND_3;
      ST_ND_3:   state_next = ST_ND_4;
      ST_ND_4:   state_next = ST_ND_5;
      ST_ND_5: begin
        if (!j_eq_i) state_next = ST_ND_0;
        else if (i == '0) state_next = ST_IDLE;
        else state_next = ST_LVL_RD;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // multiplier operands and memory control
  always_comb begin
    mul_a     = node;
    mul_b     = up_factor;
    val_we    = 1'b0;
    val_waddr = j;
    val_wdata = payoff;
    val_raddr = '0;
    prc_we    = 1'b0;
    prc_waddr = j;
    prc_wdata = rs;
    prc_raddr = i;
    case (state)
      ST_ROW_W: begin
        prc_we = 1'b1;
        mul_a  = rs;
        mul_b  = down_factor;
      end
      ST_TRM_W:  val_we = 1'b1;
      ST_TRM_U1: mul_a = sc;
      ST_ND_0:   val_raddr = j + ADDR_W'(1);
      ST_ND_1:   mul_a = sc;
      ST_ND_2: begin
        mul_a = v1;
        mul_b = {1'b0, up_probability};
      end
      ST_ND_3: begin
        mul_a = v0;
        mul_b = {1'b0, pd};
      end
      ST_ND_4: begin
        mul_a = mix;
        mul_b = {1'b0, step_discount};
      end
      ST_ND_5: begin
        val_we    = 1'b1;
        val_wdata = node_v;
      end
      default: ;
    endcase
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rs <= spot_price;
        j  <= '0;
      end
      ST_ROW_W: begin
        if (j_eq_n) begin
          node <= rs;
          j    <= '0;
        end else begin
          j <= j + ADDR_W'(1);
        end
      end
      ST_ROW_M:  rs <= sc;
      ST_TRM_W: begin
        if (j_eq_n) i <= ADDR_W'(step_count - STEP_W'(1));
        else j <= j + ADDR_W'(1);
      end
      ST_TRM_U2: node <= sc;
      ST_LVL_LD: begin
        node <= prc_rdata;
        v0   <= val_rdata;
        j    <= '0;
      end
      ST_ND_1:   v1 <= val_rdata;
      ST_ND_2:   if (j != '0) node <= sc;
      ST_ND_3:   acc <= prod;
      ST_ND_5: begin
        v0 <= v1;
        if (!j_eq_i) j <= j + ADDR_W'(1);
        else if (i != '0) i <= i - ADDR_W'(1);
      end
      default: ;
    endcase
  end

  // state, result word and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      done           <= 1'b0;
      fair_value     <= '0;
      status         <= 1'b0;
      up_factor      <= FACTOR_ONE;
      down_factor    <= FACTOR_ONE;
      up_probability <= 31'(FACTOR_ONE >> 1);
      step_discount  <= 31'(FACTOR_ONE);
      strike_price   <= '0;
      barrier_price  <= PRICE_MAX;
      step_count     <= '0;
      mode_bits      <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_IDLE && start && bad_in) begin
        done       <= 1'b1;
        fair_value <= '0;
        status     <= 1'b1;
      end else if (state == ST_ND_5 && j_eq_i && i == '0) begin
        done       <= 1'b1;
        fair_value <= node_v;
        status     <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UP_FACTOR:   up_factor      <= cfg_data;
          REG_DOWN_FACTOR: down_factor    <= cfg_data;
          REG_UP_PROB:     up_probability <= cfg_data[30:0];
          REG_DISCOUNT:    step_discount  <= cfg_data[30:0];
          REG_STRIKE:      strike_price   <= cfg_data;
          REG_BARRIER:     barrier_price  <= cfg_data;
          REG_STEP_COUNT:  step_count     <= cfg_data[STEP_W-1:0];
          REG_MODE:        mode_bits      <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // node values
  blbp_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // row start prices spot*d^k
  blbp_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_prc_ram (
    .clk   (clk),
    .we    (prc_we),
    .waddr (prc_waddr),
    .wdata (prc_wdata),
    .raddr (prc_raddr),
    .rdata (prc_rdata)
  );

`ifndef SYNTHESIS
  // an error word always carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> fair_value == '0)
    else $error("error word with nonzero value");

  // a lattice result only follows the last root node update
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done && !status |-> $past(state) == ST_ND_5)
    else $error("result word without root update");

  // node index never passes the level index during induction
  a_j_le_i: assert property (@(posedge clk) disable iff (rst)
    state == ST_ND_5 |-> j <= i)
    else $error("node index past level");

  // no memory write while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !val_we && !prc_we)
    else $error("memory write while idle");
`endif

endmodule
